// ===== rtl/dense_neuron_mac_tanh_top_defines.svh =====
// Assertion macros for the dense neuron block.
`ifndef DENSE_NEURON_MAC_TANH_TOP_DEFINES_SVH
`define DENSE_NEURON_MAC_TANH_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DNMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dense neuron assertion failed");

// Check that cons holds in the cycle after ante.
`define DNMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dense neuron assertion failed");

`endif

// ===== rtl/dnmt_pkg.sv =====
// Widths and fixed-point constants of the dense neuron block.
package dnmt_pkg;

    localparam int IN_W        = 16;
    localparam int PROD_W      = 2 * IN_W;
    localparam int ACC_W       = 48;
    localparam int Z_W         = 16;
    localparam int Y_W         = 14;
    localparam int IDX_W       = 10;
    localparam int FRAC_BITS   = 12;
    localparam int MAX_NEURONS = 1024;

    localparam int Q_SCALE = 1 << FRAC_BITS;
    localparam int Q_ONE   = Q_SCALE;
    localparam int Q_HALF  = Q_SCALE / 2;
    localparam int Q_T_HI  = (1800 * Q_SCALE + 500) / 1000;
    localparam int Q_T_LO  = (657 * Q_SCALE + 500) / 1000;
    localparam int Q_SLOPE = (300 * Q_SCALE + 500) / 1000;
    localparam int Q_OFFS  = (460 * Q_SCALE + 500) / 1000;

    localparam int Z_MAX = (1 << (Z_W - 1)) - 1;
    localparam int Z_MIN = -(1 << (Z_W - 1));

    localparam int CONST_W  = 13;
    localparam int SP_W     = Z_W + CONST_W;
    localparam int Y_CALC_W = 20;

endpackage

// ===== rtl/dense_neuron_mac_tanh_top.sv =====
// Streamed dense-layer neuron: multiply-accumulate, bias, saturate, piecewise tanh.
// One term is taken every cycle while the result side keeps up. The path runs input
// register, 16x16 product register, 48-bit accumulator add, shift and saturate, 0.3
// slope product register, then the tanh select into the output register. Terms that
// are not last leave the pipe at the accumulator add, so the input stalls only once a
// result held at the stalled output has backed up all four result stages and the
// input and product stages are both occupied. Values are Q4.12, the activation
// output is Q2.12, the accumulator is Q24.24 and wraps, and the neuron index wraps
// after 1024 neurons.
`include "dense_neuron_mac_tanh_top_defines.svh"

module dense_neuron_mac_tanh_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [dnmt_pkg::IN_W-1:0]   i_activation_in,
    input  logic signed [dnmt_pkg::IN_W-1:0]   i_weight,
    input  logic signed [dnmt_pkg::IN_W-1:0]   i_bias,
    input  logic                               i_last_term,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [dnmt_pkg::Z_W-1:0]    o_z_value,
    output logic signed [dnmt_pkg::Y_W-1:0]    o_activation_out,
    output logic        [dnmt_pkg::IDX_W-1:0]  o_neuron_index,
    output logic                               o_saturated
);

    localparam int ACC_W    = dnmt_pkg::ACC_W;
    localparam int Y_CALC_W = dnmt_pkg::Y_CALC_W;
    localparam int SP_W     = dnmt_pkg::SP_W;
    localparam int FRAC     = dnmt_pkg::FRAC_BITS;

    localparam logic signed [ACC_W-1:0]    Z_MAX_EXT = ACC_W'(dnmt_pkg::Z_MAX);
    localparam logic signed [ACC_W-1:0]    Z_MIN_EXT = ACC_W'(dnmt_pkg::Z_MIN);
    localparam logic signed [Y_CALC_W-1:0] Y_ONE     = Y_CALC_W'(dnmt_pkg::Q_ONE);
    localparam logic signed [Y_CALC_W-1:0] Y_OFFS    = Y_CALC_W'(dnmt_pkg::Q_OFFS);
    localparam logic signed [Y_CALC_W-1:0] Y_T_HI    = Y_CALC_W'(dnmt_pkg::Q_T_HI);
    localparam logic signed [Y_CALC_W-1:0] Y_T_LO    = Y_CALC_W'(dnmt_pkg::Q_T_LO);
    localparam logic signed [SP_W-1:0]     SP_SLOPE  = SP_W'(dnmt_pkg::Q_SLOPE);
    localparam logic signed [SP_W-1:0]     SP_HALF   = SP_W'(dnmt_pkg::Q_HALF);
    localparam logic [31:0]                CNT_LAST  = 32'(dnmt_pkg::MAX_NEURONS - 1);

    localparam logic signed [dnmt_pkg::Y_W-1:0] O_Y_ONE = dnmt_pkg::Y_W'(dnmt_pkg::Q_ONE);
    localparam logic signed [dnmt_pkg::Z_W-1:0] O_Z_MAX = dnmt_pkg::Z_W'(dnmt_pkg::Z_MAX);
    localparam logic signed [dnmt_pkg::Z_W-1:0] O_Z_MIN = dnmt_pkg::Z_W'(dnmt_pkg::Z_MIN);

    // input stage
    logic                                r_a_v;
    logic signed [dnmt_pkg::IN_W-1:0]    r_a_act, r_a_wt, r_a_bias;
    logic                                r_a_last;
    // product stage
    logic                                r_b_v;
    logic signed [dnmt_pkg::PROD_W-1:0]  r_b_prod;
    logic signed [dnmt_pkg::IN_W-1:0]    r_b_bias;
    logic                                r_b_last;
    // accumulate stage
    logic signed [ACC_W-1:0]             r_acc;
    logic        [dnmt_pkg::IDX_W-1:0]   r_cnt;
    logic                                r_c_v;
    logic signed [ACC_W-1:0]             r_c_sum;
    logic        [dnmt_pkg::IDX_W-1:0]   r_c_idx;
    // saturate stage
    logic                                r_d_v;
    logic signed [dnmt_pkg::Z_W-1:0]     r_d_z;
    logic                                r_d_sat;
    logic        [dnmt_pkg::IDX_W-1:0]   r_d_idx;
    // slope stage
    logic                                r_e_v;
    logic signed [dnmt_pkg::Z_W-1:0]     r_e_z;
    logic signed [Y_CALC_W-1:0]          r_e_s;
    logic                                r_e_sat;
    logic        [dnmt_pkg::IDX_W-1:0]   r_e_idx;
    // output stage
    logic                                r_o_v;
    logic signed [dnmt_pkg::Z_W-1:0]     r_o_z;
    logic signed [dnmt_pkg::Y_W-1:0]     r_o_y;
    logic        [dnmt_pkg::IDX_W-1:0]   r_o_idx;
    logic                                r_o_sat;

    logic                                en_a, en_b, en_c, en_d, en_e, en_o;
    logic                                acc_take, last_take;
    logic signed [ACC_W-1:0]             n_sum;
    logic        [dnmt_pkg::IDX_W-1:0]   n_cnt;
    logic signed [ACC_W-1:0]             z_full;
    logic signed [dnmt_pkg::Z_W-1:0]     n_z;
    logic                                n_sat;
    logic signed [SP_W-1:0]              slope_prod;
    logic signed [SP_W-1:0]              slope_shift;
    logic signed [Y_CALC_W-1:0]          z_ext;
    logic signed [Y_CALC_W-1:0]          n_y_raw;
    logic signed [Y_CALC_W-1:0]          n_y;

    assign en_o = !r_o_v || !i_out_stall;
    assign en_e = !r_e_v || en_o;
    assign en_d = !r_d_v || en_e;
    assign en_c = !r_c_v || en_d;
    assign en_b = !r_b_v || en_c;
    assign en_a = !r_a_v || en_b;
    assign o_in_stall = !en_a;

    assign acc_take  = r_b_v && en_c;
    assign last_take = acc_take && r_b_last;

    always_comb begin
        n_sum = r_acc + ACC_W'(r_b_prod);
        if (r_b_last) begin
            n_sum = n_sum + (ACC_W'(r_b_bias) <<< FRAC);
        end
    end

    assign n_cnt = ({22'd0, r_cnt} == CNT_LAST) ? '0 : r_cnt + 1'b1;

    always_comb begin
        z_full = r_c_sum >>> FRAC;
        priority if (z_full > Z_MAX_EXT) begin
            n_z   = dnmt_pkg::Z_W'(dnmt_pkg::Z_MAX);
            n_sat = 1'b1;
        end else if (z_full < Z_MIN_EXT) begin
            n_z   = dnmt_pkg::Z_W'(dnmt_pkg::Z_MIN);
            n_sat = 1'b1;
        end else begin
            n_z   = z_full[dnmt_pkg::Z_W-1:0];
            n_sat = 1'b0;
        end
    end

    assign slope_prod  = SP_SLOPE * SP_W'(r_d_z) + SP_HALF;
    assign slope_shift = slope_prod >>> FRAC;

    always_comb begin
        z_ext = Y_CALC_W'(r_e_z);
        priority if (z_ext < -Y_T_HI) begin
            n_y_raw = -Y_ONE;
        end else if (z_ext < -Y_T_LO) begin
            n_y_raw = r_e_s - Y_OFFS;
        end else if (z_ext < Y_T_LO) begin
            n_y_raw = z_ext;
        end else if (z_ext < Y_T_HI) begin
            n_y_raw = r_e_s + Y_OFFS;
        end else begin
            n_y_raw = Y_ONE;
        end
        priority if (n_y_raw > Y_ONE) begin
            n_y = Y_ONE;
        end else if (n_y_raw < -Y_ONE) begin
            n_y = -Y_ONE;
        end else begin
            n_y = n_y_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_o_v <= 1'b0;
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            if (en_a) begin
                r_a_v <= i_in_valid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_c) begin
                r_c_v <= r_b_v && r_b_last;
            end
            if (en_d) begin
                r_d_v <= r_c_v;
            end
            if (en_e) begin
                r_e_v <= r_d_v;
            end
            if (en_o) begin
                r_o_v <= r_e_v;
            end
            if (acc_take) begin
                r_acc <= r_b_last ? '0 : n_sum;
            end
            if (last_take) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_act  <= i_activation_in;
            r_a_wt   <= i_weight;
            r_a_bias <= i_bias;
            r_a_last <= i_last_term;
        end
        if (en_b) begin
            r_b_prod <= r_a_act * r_a_wt;
            r_b_bias <= r_a_bias;
            r_b_last <= r_a_last;
        end
        if (en_c) begin
            r_c_sum <= n_sum;
            r_c_idx <= r_cnt;
        end
        if (en_d) begin
            r_d_z   <= n_z;
            r_d_sat <= n_sat;
            r_d_idx <= r_c_idx;
        end
        if (en_e) begin
            r_e_z   <= r_d_z;
            r_e_s   <= slope_shift[Y_CALC_W-1:0];
            r_e_sat <= r_d_sat;
            r_e_idx <= r_d_idx;
        end
        if (en_o) begin
            r_o_z   <= r_e_z;
            r_o_y   <= n_y[dnmt_pkg::Y_W-1:0];
            r_o_idx <= r_e_idx;
            r_o_sat <= r_e_sat;
        end
    end

    assign o_out_valid      = r_o_v;
    assign o_z_value        = r_o_z;
    assign o_activation_out = r_o_y;
    assign o_neuron_index   = r_o_idx;
    assign o_saturated      = r_o_sat;

    `DNMT_ASSERT_SAME(a_act_range, i_clk, i_rst_n, r_o_v, (r_o_y <= O_Y_ONE) && (r_o_y >= -O_Y_ONE))
    `DNMT_ASSERT_SAME(a_sat_extreme, i_clk, i_rst_n, r_o_v && r_o_sat, (r_o_z == O_Z_MAX) || (r_o_z == O_Z_MIN))
    `DNMT_ASSERT_NEXT(a_acc_clear, i_clk, i_rst_n, last_take, (r_acc == '0) && r_c_v)

endmodule

// ===== test/dense_neuron_mac_tanh_top_tb.sv =====
// Testbench for the streamed dense neuron: multiply-accumulate, bias, saturation and tanh.
`timescale 1ns / 100ps

module dense_neuron_mac_tanh_top_tb;

    localparam int IN_W   = dnmt_pkg::IN_W;
    localparam int PROD_W = dnmt_pkg::PROD_W;
    localparam int ACC_W  = dnmt_pkg::ACC_W;
    localparam int Z_W    = dnmt_pkg::Z_W;
    localparam int Y_W    = dnmt_pkg::Y_W;
    localparam int IDX_W  = dnmt_pkg::IDX_W;
    localparam int FRAC   = dnmt_pkg::FRAC_BITS;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic signed [Z_W-1:0] z_value;
        logic signed [Y_W-1:0] activation_out;
        logic [IDX_W-1:0]      neuron_index;
        logic                  saturated;
    } t_neuron_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [IN_W-1:0]   i_activation_in = '0;
    logic signed [IN_W-1:0]   i_weight = '0;
    logic signed [IN_W-1:0]   i_bias = '0;
    logic                     i_last_term = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [Z_W-1:0]    o_z_value;
    logic signed [Y_W-1:0]    o_activation_out;
    logic [IDX_W-1:0]         o_neuron_index;
    logic                     o_saturated;

    logic signed [ACC_W-1:0]  acc_model = '0;
    logic [IDX_W-1:0]         index_model = '0;
    t_neuron_result           pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    dense_neuron_mac_tanh_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_activation_in  (i_activation_in),
        .i_weight         (i_weight),
        .i_bias           (i_bias),
        .i_last_term      (i_last_term),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_z_value        (o_z_value),
        .o_activation_out (o_activation_out),
        .o_neuron_index   (o_neuron_index),
        .o_saturated      (o_saturated)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [IN_W-1:0] rand_in(input int span);
        if (span == 0) begin
            return IN_W'($urandom);
        end
        return IN_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic bit neuron_step(input logic signed [IN_W-1:0] a,
                                       input logic signed [IN_W-1:0] w,
                                       input logic signed [IN_W-1:0] b,
                                       input logic last,
                                       output t_neuron_result r);
        logic signed [PROD_W-1:0] prod;
        longint z;
        longint s;
        longint y;
        bit clipped;
        prod = a * w;
        acc_model = acc_model + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        if (!last) begin
            return 1'b0;
        end
        acc_model = acc_model + {{(ACC_W-IN_W-FRAC){b[IN_W-1]}}, b, {FRAC{1'b0}}};
        z = acc_model;
        z = z >>> FRAC;
        clipped = 1'b0;
        if (z > dnmt_pkg::Z_MAX) begin
            z = dnmt_pkg::Z_MAX;
            clipped = 1'b1;
        end else if (z < dnmt_pkg::Z_MIN) begin
            z = dnmt_pkg::Z_MIN;
            clipped = 1'b1;
        end
        s = (dnmt_pkg::Q_SLOPE * z + dnmt_pkg::Q_HALF) >>> FRAC;
        if (z < -dnmt_pkg::Q_T_HI) begin
            y = -dnmt_pkg::Q_ONE;
        end else if (z < -dnmt_pkg::Q_T_LO) begin
            y = s - dnmt_pkg::Q_OFFS;
        end else if (z < dnmt_pkg::Q_T_LO) begin
            y = z;
        end else if (z < dnmt_pkg::Q_T_HI) begin
            y = s + dnmt_pkg::Q_OFFS;
        end else begin
            y = dnmt_pkg::Q_ONE;
        end
        if (y > dnmt_pkg::Q_ONE) begin
            y = dnmt_pkg::Q_ONE;
        end
        if (y < -dnmt_pkg::Q_ONE) begin
            y = -dnmt_pkg::Q_ONE;
        end
        r.z_value = z[Z_W-1:0];
        r.activation_out = y[Y_W-1:0];
        r.neuron_index = index_model;
        r.saturated = clipped;
        acc_model = '0;
        index_model = index_model + 1'b1;
        return 1'b1;
    endfunction

    task automatic send_term(input logic signed [IN_W-1:0] a,
                             input logic signed [IN_W-1:0] w,
                             input logic signed [IN_W-1:0] b,
                             input logic last);
        t_neuron_result r;
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_activation_in = a;
        i_weight = w;
        i_bias = b;
        i_last_term = last;
        do @(posedge i_clk); while (o_in_stall);
        if (neuron_step(a, w, b, last, r)) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic send_random_neuron(output int len);
        int style;
        int span;
        int bias_span;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
        style = $urandom_range(0, 2);
        span = (style == 0) ? 0 : (style == 1) ? 4096 : 700;
        bias_span = (style == 0) ? 0 : 9000;
        for (int k = 0; k < len; k++) begin
            if (k == len - 1) begin
                send_term(rand_in(span), rand_in(span), rand_in(bias_span), 1'b1);
            end else begin
                send_term(rand_in(span), rand_in(span), rand_in(0), 1'b0);
            end
        end
    endtask

    task automatic wait_drained(input int settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic test_extremes;
        send_term(-16'sd32768, -16'sd32768, 16'sd0, 1'b0);
        send_term(-16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
        send_term(16'sd32767, -16'sd32768, -16'sd32768, 1'b1);
        send_term(16'sd32767, 16'sd32767, -16'sd1, 1'b1);
        send_term(-16'sd32768, 16'sd1, -16'sd32768, 1'b1);
        send_term(16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_term(-16'sd1, 16'sd1, 16'sd0, 1'b1);
        send_term(16'sd1, 16'sd1, 16'sd0, 1'b1);
        send_term(16'sd4096, 16'sd4096, 16'sd0, 1'b1);
        // bias on a term that is not last must be ignored
        send_term(16'sd100, 16'sd100, 16'sd32767, 1'b0);
        send_term(16'sd0, 16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_tanh_segments;
        int edges [11] = '{dnmt_pkg::Z_MIN, -dnmt_pkg::Q_T_HI - 1, -dnmt_pkg::Q_T_HI,
                           -dnmt_pkg::Q_T_LO - 1, -dnmt_pkg::Q_T_LO, 0,
                           dnmt_pkg::Q_T_LO - 1, dnmt_pkg::Q_T_LO,
                           dnmt_pkg::Q_T_HI - 1, dnmt_pkg::Q_T_HI, dnmt_pkg::Z_MAX};
        foreach (edges[k]) begin
            send_term(16'sd0, 16'sd0, IN_W'(edges[k]), 1'b1);
        end
    endtask

    task automatic test_random_neurons(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            send_random_neuron(len);
            sent += len;
        end
    endtask

    task automatic test_drain_pause;
        int len;
        repeat (4) send_random_neuron(len);
        wait_drained(8);
        repeat (4) send_random_neuron(len);
    endtask

    task automatic test_output_backpressure;
        hold_request = 120;
        repeat (30) send_term(rand_in(2048), rand_in(2048), rand_in(8192), 1'b1);
    endtask

    task automatic test_index_wrap;
        int n_terms;
        n_terms = dnmt_pkg::MAX_NEURONS + 8 - int'(index_model);
        repeat (n_terms) send_term(rand_in(0), rand_in(0), rand_in(0), 1'b1);
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = int'($urandom_range(0, 99)) < recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_neuron_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: neuron_index %0d", o_neuron_index);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_z_value !== want.z_value) begin
                    $error("z_value: expected %0d, actual %0d", want.z_value, o_z_value);
                    mismatch_count++;
                end
                if (o_activation_out !== want.activation_out) begin
                    $error("activation_out: expected %0d, actual %0d",
                           want.activation_out, o_activation_out);
                    mismatch_count++;
                end
                if (o_neuron_index !== want.neuron_index) begin
                    $error("neuron_index: expected %0d, actual %0d",
                           want.neuron_index, o_neuron_index);
                    mismatch_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated: expected %0d, actual %0d", want.saturated, o_saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 49;
        test_extremes;
        test_tanh_segments;
        test_random_neurons(40);

        send_idle_pct = 49;
        recv_idle_pct = 33;
        test_random_neurons(40);
        test_drain_pause;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_neurons(40);
        test_output_backpressure;
        test_index_wrap;

        wait_drained(12);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
